>>> hw/rtl/assert_macros.svh
// Assertion macros of the group reversal buffer RTL, used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is high.
`define GRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define GRB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRB_ASSERT(label, clk, rst, prop, msg)
`define GRB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/grb_pkg.sv
// Shared types, constants and helpers of the group reversal buffer.
package grb_pkg;

   // Capacity of the group store
   localparam int MAX_GROUP = 16;
   localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int KW        = $clog2(MAX_GROUP + 1);
   localparam int VALUE_W   = 32;
   localparam int CSR_W     = 5;

   // Sequencer states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } grb_state_type;

   // Map the raw size register to a usable group length (zero acts as one)
   function automatic logic [KW-1:0] eff_group_size(input logic [CSR_W-1:0] gs);
      logic [KW-1:0] k;
      if (gs == '0) begin
         k = KW'(1);
      end else if (int'(gs) > MAX_GROUP) begin
         k = KW'(MAX_GROUP);
      end else begin
         k = KW'(gs);
      end
      return k;
   endfunction

endpackage

>>> hw/rtl/grb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module grb_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port: data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/grb_ctrl.sv
// Sequencer of the group reversal buffer: fill count, drain order, output flags.
`include "assert_macros.svh"
module grb_ctrl
   import grb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [KW-1:0]    eff_k,
   input  logic             req_valid,
   input  logic             req_is_last,
   output logic             req_stall,
   output logic             rsp_valid,
   output logic             rsp_end_of_sequence,
   input  logic             rsp_stall,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr
);

   grb_state_type    state_ff, state_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic             rev_ff, rev_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_end_ff, rsp_end_in;

   logic             accept;
   logic [KW-1:0]    n_held;
   logic             full;
   logic             emit;
   logic             issue;
   logic             final_beat;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Drain bookkeeping and result flag
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      top_ff     <= top_in;
      rev_ff     <= rev_in;
      last_ff    <= last_in;
      rsp_end_ff <= rsp_end_in;
   end

   // Group decision for the incoming beat
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign n_held     = KW'(fill_ff) + KW'(1);
   assign full       = (n_held >= eff_k);
   assign emit       = full || req_is_last;
   assign issue      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign final_beat = rev_ff ? (idx_ff == '0) : (idx_ff == top_ff);

   // Next state and outputs
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      top_in     = top_ff;
      rev_in     = rev_ff;
      last_in    = last_ff;
      rsp_end_in = rsp_end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (emit) begin
                  // Full group drains newest first, short final group oldest first
                  fill_in  = '0;
                  state_in = ST_DRAIN;
                  top_in   = fill_ff;
                  rev_in   = full;
                  idx_in   = full ? fill_ff : '0;
                  last_in  = req_is_last;
               end else begin
                  fill_in = n_held[IDX_W-1:0];
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               rsp_end_in = last_ff && final_beat;
               if (final_beat) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = rev_ff ? (idx_ff - IDX_W'(1)) : (idx_ff + IDX_W'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output beat is held while stalled, refilled on each read
   assign rsp_valid_in = issue || (rsp_valid_ff && rsp_stall);

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_end_of_sequence = rsp_end_ff;
   assign wr_en               = accept;
   assign wr_addr             = fill_ff;
   assign rd_en               = issue;
   assign rd_addr             = idx_ff;

   `GRB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset does not clear sequencer")
   `GRB_ASSERT(a_drain_start, clock, reset, (accept && emit) |=> (state_ff == ST_DRAIN && fill_ff == '0), "emitting beat does not start drain")
   `GRB_ASSERT(a_idx_range, clock, reset, (state_ff == ST_DRAIN) |-> (idx_ff <= top_ff), "drain index beyond group")
   `GRB_ASSERT(a_issue_valid, clock, reset, issue |=> rsp_valid_ff, "read issued without output beat")

endmodule

>>> hw/rtl/group_reversal_buffer.sv
// Top level of the group reversal buffer: size register, group store, sequencer.
//
// The group reversal buffer collects values into a group store of MAX_GROUP
// (16) entries and emits each complete group newest first; a short final group
// is emitted in arrival order when the end mark comes, and the last result of
// a sequence carries end_of_sequence. An item that completes no group does not
// stall the input, and the next item may follow at once. An item that releases a
// group of n values stalls the input while the group drains through the single
// read port of the store, one result per cycle when the output is not stalled.
// The first result is read in the drain state of the sequencer and comes out of
// the read register of the store. Group size writes are accepted at any time
// and are meant to be made while the block is idle.
module group_reversal_buffer
   import grb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_W-1:0]          csr_group_size,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value_res,
   output logic                      rsp_end_of_sequence
);

   logic [CSR_W-1:0]   group_size_ff, group_size_in;
   logic [KW-1:0]      eff_k;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // Size register
   assign csr_ready     = 1'b1;
   assign group_size_in = (csr_valid && csr_ready) ? csr_group_size : group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= CSR_W'(1);
      end else begin
         group_size_ff <= group_size_in;
      end
   end

   assign eff_k = eff_group_size(group_size_ff);

   // Sequencer
   grb_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .eff_k               (eff_k),
      .req_valid           (req_valid),
      .req_is_last         (req_is_last),
      .req_stall           (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .rsp_stall           (rsp_stall),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr)
   );

   // Group store; its read register doubles as the output value register
   grb_ram #(
      .DATA_W (VALUE_W),
      .DEPTH  (MAX_GROUP)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_value_res = $signed(rd_data);

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the group reversal buffer: directed and random value streams.
module testbench
   import grb_pkg::*;
();

   // Expected order of values for each accepted item, kept per group as the block should
   class group_reverse_tracker;
      typedef struct {
         logic [VALUE_W-1:0] value;
         logic               eos;
      } out_beat_type;

      logic [CSR_W-1:0]   size_reg;
      logic [VALUE_W-1:0] held_values[MAX_GROUP];
      int unsigned        held_count;
      out_beat_type       pending_outputs[$];
      int unsigned        error_count;

      function new();
         size_reg = CSR_W'(1);
         held_count = 0;
         error_count = 0;
      endfunction

      // Store the value, then release the group reversed or the short tail in order
      function void accept_value(input logic [VALUE_W-1:0] value, input logic last);
         int unsigned  group_len;
         int unsigned  n;
         out_beat_type beat;
         group_len = (size_reg == '0) ? 1 :
                     ((int'(size_reg) > MAX_GROUP) ? MAX_GROUP : int'(size_reg));
         if (held_count < MAX_GROUP) begin
            held_values[held_count] = value;
            held_count++;
         end
         n = held_count;
         if (n >= group_len) begin
            for (int unsigned i = 0; i < n; i++) begin
               beat.value = held_values[n - 1 - i];
               beat.eos   = last && (i == n - 1);
               pending_outputs.push_back(beat);
            end
            held_count = 0;
         end else if (last) begin
            for (int unsigned i = 0; i < n; i++) begin
               beat.value = held_values[i];
               beat.eos   = (i == n - 1);
               pending_outputs.push_back(beat);
            end
            held_count = 0;
         end
      endfunction

      // Compare one output beat with the oldest expectation
      function void compare_output(input logic [VALUE_W-1:0] value, input logic eos);
         out_beat_type want;
         if (pending_outputs.size() == 0) begin
            $error("unexpected output beat: value_res=%h end_of_sequence=%b", value, eos);
            error_count++;
            return;
         end
         want = pending_outputs.pop_front();
         if (value !== want.value) begin
            $error("value_res mismatch: expected %h actual %h", want.value, value);
            error_count++;
         end
         if (eos !== want.eos) begin
            $error("end_of_sequence mismatch: expected %b actual %b", want.eos, eos);
            error_count++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_W-1:0]          csr_group_size = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_is_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value_res;
   logic                      rsp_end_of_sequence;

   group_reverse_tracker tracker = new();

   bit hold_request = 1'b0;
   int req_quiet_left = 0;
   int rsp_quiet_left = 0;

   group_reversal_buffer uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_group_size      (csr_group_size),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_value           (req_value),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_res       (rsp_value_res),
      .rsp_end_of_sequence (rsp_end_of_sequence)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw a random wait, with occasional stretches of no waiting
   function automatic int draw_wait(ref int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(VALUE_W-1){1'b0}}};
         1: return {1'b0, {(VALUE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Offer one beat on the request channel; called and returns at a falling edge
   task automatic send_value(input logic [VALUE_W-1:0] value, input logic last);
      int gap;
      gap = draw_wait(req_quiet_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      tracker.accept_value(value, last);
      @(negedge clock);
   endtask

   // Wait until every expected beat has come and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_outputs.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_group_size(input logic [CSR_W-1:0] size);
      csr_valid      <= 1'b1;
      csr_group_size <= size;
      do @(posedge clock); while (!csr_ready);
      tracker.size_reg = size;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: stall a drawn number of cycles per beat, once for a long stretch
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = draw_wait(rsp_quiet_left);
         if (hold_request) begin
            gap = 150;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Check every output beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.compare_output(rsp_value_res, rsp_end_of_sequence);
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int sent;
      int phase_len;
      bit hold_done;
      logic [CSR_W-1:0] size;
      sent = 0;
      hold_done = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Pass-through at the reset size, value extremes
      send_value(32'h8000_0000, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b1);
      send_value(32'h0000_0000, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b1);
      settle();

      // Zero size acts as one
      write_group_size('0);
      send_value(32'h5555_5555, 1'b0);
      send_value(32'hAAAA_AAAA, 1'b1);
      settle();

      // Full group, end mark on a full group, short final group
      write_group_size(CSR_W'(3));
      for (int i = 1; i <= 8; i++) begin
         send_value(VALUE_W'(i), (i == 6) || (i == 8));
      end
      settle();

      // Shrink the size while a group is partly held
      write_group_size(CSR_W'(8));
      for (int i = 9; i <= 11; i++) send_value(VALUE_W'(i), 1'b0);
      settle();
      write_group_size(CSR_W'(2));
      send_value(VALUE_W'(12), 1'b0);
      settle();

      // Oversized size saturates
      write_group_size('1);
      for (int i = 13; i <= 17; i++) send_value(VALUE_W'(i), i == 17);
      settle();

      // Random phases, each with its own size
      while (sent < 170) begin
         case ($urandom_range(0, 9))
            0: size = '0;
            1: size = CSR_W'($urandom_range(MAX_GROUP + 1, (1 << CSR_W) - 1));
            2: size = CSR_W'(MAX_GROUP);
            default: size = CSR_W'($urandom_range(1, 6));
         endcase
         phase_len = (int'(size) >= MAX_GROUP) ? $urandom_range(16, 40) : $urandom_range(5, 30);
         if (!hold_done && sent >= 80) begin
            size = CSR_W'(4);
            phase_len = 30;
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         write_group_size(size);
         for (int i = 0; i < phase_len; i++) begin
            send_value(draw_value(),
                       ($urandom_range(0, 9) == 0) ||
                       ((i == phase_len - 1) && $urandom_range(0, 1)));
            sent++;
         end
         settle();
      end

      repeat (20) @(negedge clock);
      if (tracker.error_count == 0 && tracker.pending_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
